/* rtl/core/swmf_pkg.sv */
// shared types and constants for the sliding window median filter
// no dependencies

package swmf_pkg;

  localparam int unsigned DATA_W = 16;

  typedef logic signed [DATA_W-1:0] swmf_sample_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic load;
    logic count;
  } swmf_ctl_t;

endpackage

/* rtl/core/swmf_cell.sv */
// one window cell: holds a stored sample, a rotating copy and rank counters
// depends on swmf_pkg

module swmf_cell
  import swmf_pkg::*;
#(
  parameter int unsigned WINDOW = 10
) (
  input  logic         clk_i,
  input  swmf_ctl_t    ctl_i,
  input  swmf_sample_t sample_i,
  input  swmf_sample_t rot_i,
  output swmf_sample_t sample_o,
  output swmf_sample_t rot_o,
  output logic         hit_o,
  output swmf_sample_t pick_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned RANK  = (WINDOW - 1) / 2;

  swmf_sample_t sample_q, sample_d;
  swmf_sample_t rot_q, rot_d;
  logic [CNT_W-1:0] lt_q, lt_d;
  logic [CNT_W-1:0] le_q, le_d;

  always_comb begin
    sample_d = sample_q;
    rot_d    = rot_q;
    lt_d     = lt_q;
    le_d     = le_q;
    if (ctl_i.load) begin
      sample_d = sample_i;
      rot_d    = sample_i;
      lt_d     = '0;
      le_d     = '0;
    end else if (ctl_i.count) begin
      rot_d = rot_i;
      if (rot_q < sample_q) begin
        lt_d = lt_q + CNT_W'(1);
      end
      if (rot_q <= sample_q) begin
        le_d = le_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    rot_q    <= rot_d;
    lt_q     <= lt_d;
    le_q     <= le_d;
  end

  assign sample_o = sample_q;
  assign rot_o    = rot_q;
  // this sample sits at the median rank (ties give equal values)
  assign hit_o    = (lt_q <= CNT_W'(RANK)) && (le_q > CNT_W'(RANK));
  assign pick_o   = hit_o ? sample_q : '0;

endmodule

/* rtl/core/sliding_window_median_filter.sv */
// sliding window lower median filter over the last WINDOW samples
// a new sample is taken only in idle, once the last result has entered the output register,
// which waits while a beat there is not taken; warm-up samples pass straight through, full-window
// samples wait for the ring rotation through the cell chain, one compare step per cycle
// reset clears state, fill and rotation counts, full flag and output valid; window contents stay undefined
// depends on swmf_pkg and swmf_cell

module sliding_window_median_filter
  import swmf_pkg::*;
#(
  parameter int unsigned WINDOW = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [15:0] sample_x
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [15:0] filtered_x
  output logic              m_axis_tuser    // [0] window_full
);

  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned CNT_W  = $clog2(WINDOW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  swmf_sample_t      pass_q, pass_d;
  logic              res_full_q, res_full_d;
  logic              out_valid_q, out_valid_d;
  swmf_sample_t      out_data_q, out_data_d;
  logic              out_full_q, out_full_d;

  swmf_ctl_t    ctl;
  swmf_sample_t sample_in;
  swmf_sample_t median;
  logic         out_free;
  logic         accept;

  swmf_sample_t cell_sample [WINDOW];
  swmf_sample_t cell_rot    [WINDOW];
  swmf_sample_t cell_pick   [WINDOW];
  logic [WINDOW-1:0] cell_hit;

  assign sample_in     = swmf_sample_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign ctl.load  = accept;
  assign ctl.count = (state_q == ST_RUN);

  // newest sample enters the top cell, rotation runs the same way as a ring
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    swmf_sample_t nxt_sample;
    swmf_sample_t nxt_rot;
    if (g == WINDOW - 1) begin : g_top
      assign nxt_sample = sample_in;
      assign nxt_rot    = cell_rot[0];
    end else begin : g_mid
      assign nxt_sample = cell_sample[g+1];
      assign nxt_rot    = cell_rot[g+1];
    end
    swmf_cell #(
      .WINDOW(WINDOW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .sample_i(nxt_sample),
      .rot_i   (nxt_rot),
      .sample_o(cell_sample[g]),
      .rot_o   (cell_rot[g]),
      .hit_o   (cell_hit[g]),
      .pick_o  (cell_pick[g])
    );
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      median = median | cell_pick[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    res_full_d  = res_full_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_full_d  = out_full_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pass_d = sample_in;
          cnt_d  = '0;
          if (fill_q < FILL_W'(WINDOW)) begin
            fill_d     = fill_q + FILL_W'(1);
            res_full_d = 1'b0;
            state_d    = ST_DONE;
          end else begin
            res_full_d = 1'b1;
            state_d    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WINDOW - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_full_q ? median : pass_q;
          out_full_d  = res_full_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      res_full_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      res_full_q  <= res_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q     <= pass_d;
    out_data_q <= out_data_d;
    out_full_q <= out_full_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_full_q;

`ifndef ASSERT_OFF
  a_full_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_full_q) |-> (fill_q == FILL_W'(WINDOW)))
    else $error("median formed before window filled");

  a_median_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_full_q) |-> (cell_hit != '0))
    else $error("no cell at median rank");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= CNT_W'(WINDOW - 1)))
    else $error("rotation count overrun");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fill_q < FILL_W'(WINDOW)) |=> (fill_q == $past(fill_q) + FILL_W'(1)))
    else $error("fill count did not advance");
`endif

endmodule

/* dv/testbench.sv */
// self-checking testbench for sliding_window_median_filter: a queue-fed stream driver,
// a result monitor and a running lower median predictor with random idling on both sides
// depends on swmf_pkg and the filter rtl
`timescale 1ns / 100ps

module testbench
  import swmf_pkg::*;
();

  localparam int unsigned WINDOW      = 10;
  localparam int unsigned MEDIAN_RANK = (WINDOW % 2) ? WINDOW / 2 : WINDOW / 2 - 1;
  localparam int unsigned RANDOM_BEATS = 1330;
  localparam int unsigned PHASE_LEN   = 150;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef enum int unsigned {
    PH_NO_IDLE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE
  } idle_phase_e;

  typedef struct {
    swmf_sample_t sample;
    idle_phase_e  phase;
  } sample_beat_t;

  typedef struct {
    swmf_sample_t filtered;
    logic         full;
  } filtered_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  sample_beat_t   sample_queue[$];
  filtered_beat_t expected_medians[$];
  swmf_sample_t   held_samples[$];
  idle_phase_e    cur_phase = PH_NO_IDLE;
  int unsigned    error_count = 0;
  int unsigned    idle_cycles = 0;

  sliding_window_median_filter #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned idle_pct(idle_phase_e phase, bit sender);
    case (phase)
      PH_SEND_IDLE:  return sender ? 62 : 0;
      PH_RECV_STALL: return sender ? 0 : 62;
      PH_BOTH_IDLE:  return 10;
      default:       return 0;
    endcase
  endfunction

  // shift the sample into the running window and queue the filter output it should give
  function automatic void predict_filtered(swmf_sample_t sample);
    swmf_sample_t   sorted[$];
    swmf_sample_t   v;
    filtered_beat_t res;
    int             j;
    if (held_samples.size() < WINDOW) begin
      held_samples = {held_samples, sample};
      res.filtered = sample;
      res.full     = 1'b0;
    end else begin
      void'(held_samples.pop_front());
      held_samples = {held_samples, sample};
      sorted = held_samples;
      for (int i = 1; i < WINDOW; i++) begin
        v = sorted[i];
        j = i - 1;
        while (j >= 0 && sorted[j] > v) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = v;
      end
      res.filtered = sorted[MEDIAN_RANK];
      res.full     = 1'b1;
    end
    expected_medians = {expected_medians, res};
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      sample_beat_t nxt;
      if (s_axis_tvalid) predict_filtered(swmf_sample_t'(s_axis_tdata));
      if (sample_queue.size() != 0 &&
          $urandom_range(99) >= idle_pct(sample_queue[0].phase, 1'b1)) begin
        nxt = sample_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.sample;
        cur_phase     <= nxt.phase;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      filtered_beat_t exp_beat;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_medians.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected output beat: filtered_x %0d window_full %0b",
                     $signed(m_axis_tdata), m_axis_tuser);
        end else begin
          exp_beat = expected_medians.pop_front();
          if (swmf_sample_t'(m_axis_tdata) !== exp_beat.filtered ||
              m_axis_tuser !== exp_beat.full) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: filtered_x exp %0d got %0d, window_full exp %0b got %0b",
                       exp_beat.filtered, $signed(m_axis_tdata), exp_beat.full,
                       m_axis_tuser);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct(cur_phase, 1'b0));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    sample_beat_t beat;
    logic [15:0]  directed[$];
    directed = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa,
                 16'h00ff, 16'hff00, 16'h8001,
                 // window saturates here; runs of equal samples follow
                 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'hfffb, 16'hfffb, 16'hfffb,
                 16'h0003, 16'h0003, 16'h7ffe, 16'h8000, 16'h0000};
    foreach (directed[i]) begin
      beat.sample = directed[i];
      beat.phase  = PH_NO_IDLE;
      sample_queue = {sample_queue, beat};
    end
    for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: beat.sample = swmf_sample_t'($urandom_range(16'hffff));
        5, 6:          beat.sample = swmf_sample_t'($urandom_range(8) - 4);
        7:             beat.sample = swmf_sample_t'(16'h8000 + $urandom_range(3));
        8:             beat.sample = swmf_sample_t'(16'h7fff - $urandom_range(3));
        default:       beat.sample = swmf_sample_t'($urandom_range(40) + 1000);
      endcase
      beat.phase = idle_phase_e'((i / PHASE_LEN) % 4);
      sample_queue = {sample_queue, beat};
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sample_queue.size() != 0 || s_axis_tvalid || expected_medians.size() != 0)
      @(posedge clk_i);
    repeat (4 * WINDOW) @(posedge clk_i);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
